/* rtl/vmpa_pkg.sv */
package vmpa_pkg;

    // Sizes that follow from the fixed field formats.
    localparam int MAX_NEIGHBORS = 16;
    localparam int FRAC_BITS     = 16;
    localparam int QUEUE_DEPTH   = 2;

    // Tie margin of 1e-6 m^2, rounded to the nearest unit of the squared format.
    localparam longint unsigned EPS_Q =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

    // Register indexes of the configuration port.
    localparam logic REG_VOXEL_SIZE  = 1'b0;
    localparam logic REG_MATCH_COUNT = 1'b1;

    // Item kinds.
    localparam logic CMD_POINT    = 1'b0;
    localparam logic CMD_NEIGHBOR = 1'b1;

    typedef enum logic [1:0] {
        DEC_ADD  = 2'd0,
        DEC_LONE = 2'd1,
        DEC_SKIP = 2'd2
    } t_dec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIST,
        ST_FIN,
        ST_EMIT
    } t_state;

    // One queued request as it travels from the front to the back.
    typedef struct packed {
        logic        command;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic        map_ready;
        logic [4:0]  neighbor_count;
        logic        last_neighbor;
    } t_item;

    // Saturating unsigned add of two squared distances.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

/* rtl/vmpa_front.sv */
module vmpa_front
    import vmpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_map_ready,
    input  logic [4:0]  i_neighbor_count,
    input  logic        i_last_neighbor,
    output t_item       o_item,
    output logic        o_item_valid,
    input  logic        i_item_pop
);

    t_item      r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_ready      = (r_cnt != 2'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

    // Request storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{command:        i_command,
                             coord_x:        i_coord_x,
                             coord_y:        i_coord_y,
                             coord_z:        i_coord_z,
                             map_ready:      i_map_ready,
                             neighbor_count: i_neighbor_count,
                             last_neighbor:  i_last_neighbor};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_item_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_item_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* rtl/vmpa_rem.sv */
module vmpa_rem
    import vmpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [22:0] i_divisor,
    output logic        o_done,
    output logic [22:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [22:0] r_rem;
    logic [23:0] trial;

    // One restoring step a cycle, most significant dividend bit first.
    assign trial  = {r_rem, r_q[31]};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[30:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                r_rem <= 23'(trial - {1'b0, i_divisor});
            end else begin
                r_rem <= trial[22:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/vmpa_back.sv */
module vmpa_back
    import vmpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_pop,
    input  logic [22:0] i_voxel_size,
    input  logic [4:0]  i_match_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_decision,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z
);

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_pt  [3];
    logic [31:0] r_nb  [3];
    logic [31:0] r_ctr [3];
    logic [63:0] r_own;
    logic [63:0] r_acc;
    logic [63:0] r_sq;
    logic [4:0]  r_idx;
    logic [4:0]  r_exp;
    t_dec        r_verdict;
    t_dec        r_dec;
    logic        r_pending;
    logic        r_is_nb;
    logic        r_last;
    logic [1:0]  r_step;
    logic        r_ov;
    t_dec        r_odec;
    logic [31:0] r_opt [3];

    logic        div_start;
    logic        out_load;
    logic [22:0] edge_len;
    logic [22:0] half;
    logic [31:0] item_pt [3];
    logic [31:0] dividend [3];
    logic [22:0] rem [3];
    logic        div_done [3];
    logic [31:0] center [3];
    logic [31:0] dist_src;
    logic [32:0] dist_d;
    logic [31:0] dist_mag;
    logic [63:0] acc_next;
    logic [2:0]  far_ax;
    logic        far;
    logic [63:0] own_eps;
    logic [4:0]  nidx;
    logic        fin_done;
    t_dec        fin_verdict;
    t_dec        fin_dec;

    assign edge_len = (i_voxel_size == '0) ? 23'd1 : i_voxel_size;
    assign half     = edge_len >> 1;
    assign item_pt[0] = i_item.coord_x;
    assign item_pt[1] = i_item.coord_y;
    assign item_pt[2] = i_item.coord_z;

    // Per-axis remainder units and the voxel centers they give.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [22:0] flo;
        logic [33:0] c34;
        logic [32:0] fd;
        logic [32:0] fmag;

        assign dividend[a] = item_pt[a][31] ? (32'd0 - item_pt[a]) : item_pt[a];

        vmpa_rem u_rem (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (dividend[a]),
            .i_divisor  (edge_len),
            .o_done     (div_done[a]),
            .o_rem      (rem[a])
        );

        // Floor remainder, then center = p - r + half, saturated to 32 bits.
        assign flo = (r_pt[a][31] && rem[a] != '0) ? (edge_len - rem[a]) : rem[a];
        assign c34 = {{2{r_pt[a][31]}}, r_pt[a]} - {11'd0, flo} + {11'd0, half};
        assign center[a] = (c34[33] && !(&c34[32:31])) ? 32'h8000_0000 :
                           (!c34[33] && (|c34[32:31])) ? 32'h7FFF_FFFF : c34[31:0];

        // Lone test, per axis: neighbor more than half a voxel from the center.
        assign fd      = {r_nb[a][31], r_nb[a]} - {r_ctr[a][31], r_ctr[a]};
        assign fmag    = fd[32] ? (33'd0 - fd) : fd;
        assign far_ax[a] = fmag > {10'd0, half};
    end

    assign far = &far_ax;

    // Squared distance of one axis per cycle through the shared multiplier.
    assign dist_src = r_is_nb ? r_nb[r_step] : r_pt[r_step];
    assign dist_d   = {dist_src[31], dist_src} - {r_ctr[r_step][31], r_ctr[r_step]};
    assign dist_mag = dist_d[32] ? 32'(33'd0 - dist_d) : dist_d[31:0];
    assign acc_next = sat_add(r_acc, r_sq);

    // Neighbor verdict update.
    assign own_eps = sat_add(r_own, 64'(EPS_Q));
    assign nidx    = r_idx + 5'd1;
    always_comb begin
        fin_verdict = r_verdict;
        if (r_idx == 5'd0 && far) begin
            fin_verdict = DEC_LONE;
        end
        if (fin_verdict == DEC_ADD && r_idx < i_match_count && r_acc < own_eps) begin
            fin_verdict = DEC_SKIP;
        end
        fin_dec = DEC_ADD;
        if (fin_verdict == DEC_LONE) begin
            fin_dec = DEC_LONE;
        end else if (fin_verdict == DEC_SKIP && nidx >= i_match_count) begin
            fin_dec = DEC_SKIP;
        end
    end
    assign fin_done = r_last || (nidx >= r_exp);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.command == CMD_POINT) begin
                        if (i_item.neighbor_count == '0 || !i_item.map_ready) begin
                            n_state = ST_EMIT;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end else if (r_pending) begin
                        n_state = ST_DIST;
                    end
                end
            end
            ST_DIV: begin
                if (div_done[0]) begin
                    n_state = ST_DIST;
                end
            end
            ST_DIST: begin
                if (r_step == 2'd3) begin
                    n_state = r_is_nb ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                n_state = fin_done ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_ov || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_item_pop) begin
            r_step <= 2'd0;
            r_acc  <= '0;
            r_last <= i_item.last_neighbor;
            if (i_item.command == CMD_POINT) begin
                for (int a = 0; a < 3; a++) begin
                    r_pt[a] <= item_pt[a];
                end
                r_dec     <= DEC_ADD;
                r_is_nb   <= 1'b0;
                r_idx     <= '0;
                r_verdict <= DEC_ADD;
                r_exp     <= (i_item.neighbor_count > 5'(MAX_NEIGHBORS)) ?
                             5'(MAX_NEIGHBORS) : i_item.neighbor_count;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    r_nb[a] <= item_pt[a];
                end
                r_is_nb <= 1'b1;
            end
        end
        if (r_state == ST_DIV && div_done[0]) begin
            for (int a = 0; a < 3; a++) begin
                r_ctr[a] <= center[a];
            end
        end
        if (r_state == ST_DIST) begin
            r_step <= r_step + 2'd1;
            if (r_step != 2'd3) begin
                r_sq <= 64'(dist_mag) * 64'(dist_mag);
            end
            if (r_step != 2'd0) begin
                r_acc <= acc_next;
            end
            if (r_step == 2'd3 && !r_is_nb) begin
                r_own <= acc_next;
            end
        end
        if (r_state == ST_FIN) begin
            r_verdict <= fin_verdict;
            r_idx     <= nidx;
            r_dec     <= fin_dec;
        end
        if (out_load) begin
            r_odec <= r_dec;
            for (int a = 0; a < 3; a++) begin
                r_opt[a] <= r_pt[a];
            end
        end
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && o_item_pop && i_item.command == CMD_POINT) begin
                r_pending <= 1'b0;
            end
            if (r_state == ST_DIST && r_step == 2'd3 && !r_is_nb) begin
                r_pending <= 1'b1;
            end
            if (r_state == ST_FIN && fin_done) begin
                r_pending <= 1'b0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_decision = r_odec;
    assign o_point_x  = r_opt[0];
    assign o_point_y  = r_opt[1];
    assign o_point_z  = r_opt[2];

endmodule

/* rtl/voxel_map_point_admission.sv */
// Voxel map point admission: for each point request, followed by its neighbor
// requests, one result says whether the point is added, added as a lone voxel
// point, or skipped. A point request for which neighbors apply goes through the
// bit-serial floor division by the voxel size (32 steps) and then the
// own-distance pass; a point added at once goes straight to its result. Each
// neighbor request goes through a distance pass on the shared 32x32 multiplier,
// one axis per cycle, and a verdict step. A two-entry queue sits in front, and
// a result register lets the next request start while a result waits. Write
// configuration only while the block is idle.
module voxel_map_point_admission
    import vmpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [22:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_map_ready,
    input  logic [4:0]  i_neighbor_count,
    input  logic        i_last_neighbor,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_decision,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z
);

    logic [22:0] r_voxel_size;
    logic [4:0]  r_match_count;
    t_item       item;
    logic        item_valid;
    logic        item_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_size  <= 23'd32768;
            r_match_count <= 5'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VOXEL_SIZE:  r_voxel_size  <= i_cfg_data;
                REG_MATCH_COUNT: r_match_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    vmpa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_map_ready      (i_map_ready),
        .i_neighbor_count (i_neighbor_count),
        .i_last_neighbor  (i_last_neighbor),
        .o_item           (item),
        .o_item_valid     (item_valid),
        .i_item_pop       (item_pop)
    );

    vmpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_item_pop    (item_pop),
        .i_voxel_size  (r_voxel_size),
        .i_match_count (r_match_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_decision    (o_decision),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z)
    );

endmodule
